@@ hdl/dfs_pkg.sv @@
// shared types, widths, constants and the arc-tangent table for the decimal sine block
package dfs_pkg;

  localparam int unsigned CORDIC_STAGES_DEF = 32;

  // port field widths
  localparam int unsigned WHOLE_W = 8;
  localparam int unsigned HUND_W  = 7;
  localparam int unsigned BYTE_W  = 8;

  // angle front end widths
  localparam int unsigned AIN_W   = 15;  // whole*100 +/- hundredths
  localparam int unsigned MAG_W   = 14;  // magnitude of that, at most 12927
  localparam int unsigned V_W     = 21;  // 96*mag + 50
  localparam int unsigned PROD2_W = 43;
  localparam int unsigned QS_W    = 14;
  localparam int unsigned Q_W     = 40;  // angle in Q32 before reduction
  localparam int unsigned MOD_STEPS = 5; // angle stays below 32 turns

  // cordic datapath
  localparam int unsigned ANG_W   = 36;

  // output scaling
  localparam int unsigned PROD_W  = 43;
  localparam int unsigned SCL_W   = 11;
  localparam int unsigned SAT_W   = 7;
  localparam int unsigned RES_W   = 16;

  localparam logic signed [AIN_W-1:0] HUND_PER_UNIT = 15'sd100;

  // 2^32 = 100 * RECIP_HI + RECIP_REM
  localparam logic [Q_W-1:0]     RECIP_HI   = 40'd42949672;
  localparam logic [V_W-1:0]     RECIP_REM  = 21'd96;
  localparam logic [V_W-1:0]     ROUND_HALF = 21'd50;
  // floor(v / 100) = (v * DIV_MUL) >> DIV_SHIFT for v below 2^21
  localparam logic [PROD2_W-1:0] DIV_MUL    = 43'd2684355;
  localparam int unsigned        DIV_SHIFT  = 28;

  localparam logic signed [ANG_W-1:0] Q_PI      = 36'sh3243F6A89;
  localparam logic signed [ANG_W-1:0] Q_HALF_PI = 36'sh1921FB544;
  localparam logic signed [ANG_W-1:0] Q_TWO_PI  = 36'sh6487ED511;
  localparam logic signed [ANG_W-1:0] Q_GAIN    = 36'sh09B74EDA8;
  localparam logic signed [ANG_W-1:0] Q_PI_4    = 36'sh0C90FDAA2;

  localparam logic [PROD_W-1:0] SCALE   = 43'd100;
  localparam logic [SCL_W-1:0]  SAT_MAX = 11'd100;

  typedef struct packed {
    logic                    valid;
    logic signed [ANG_W-1:0] angle;
  } dfs_ang_t;

  typedef struct packed {
    logic                    valid;
    logic signed [ANG_W-1:0] y;
  } dfs_rot_t;

  // 2^(-i*e) in Q60, zero once the exponent runs out
  function automatic logic [63:0] arc_pow(int unsigned i, int unsigned e);
    if (i * e > 60) begin
      return 64'd0;
    end
    return 64'd1 << (60 - i * e);
  endfunction

  // atan(2^-i) in Q32 from the alternating series in Q60
  function automatic logic signed [ANG_W-1:0] arc_step(int unsigned i);
    logic [63:0] acc;
    if (i == 0) begin
      return Q_PI_4;
    end
    acc = 64'd0;
    acc = acc + arc_pow(i, 1)  / 64'd1;
    acc = acc - arc_pow(i, 3)  / 64'd3;
    acc = acc + arc_pow(i, 5)  / 64'd5;
    acc = acc - arc_pow(i, 7)  / 64'd7;
    acc = acc + arc_pow(i, 9)  / 64'd9;
    acc = acc - arc_pow(i, 11) / 64'd11;
    acc = acc + arc_pow(i, 13) / 64'd13;
    acc = acc - arc_pow(i, 15) / 64'd15;
    acc = acc + arc_pow(i, 17) / 64'd17;
    acc = acc - arc_pow(i, 19) / 64'd19;
    acc = acc + arc_pow(i, 21) / 64'd21;
    acc = acc - arc_pow(i, 23) / 64'd23;
    acc = acc + arc_pow(i, 25) / 64'd25;
    acc = acc - arc_pow(i, 27) / 64'd27;
    acc = acc + arc_pow(i, 29) / 64'd29;
    acc = acc - arc_pow(i, 31) / 64'd31;
    acc = acc + arc_pow(i, 33) / 64'd33;
    acc = acc - arc_pow(i, 35) / 64'd35;
    acc = acc + arc_pow(i, 37) / 64'd37;
    acc = acc - arc_pow(i, 39) / 64'd39;
    acc = acc + arc_pow(i, 41) / 64'd41;
    acc = acc - arc_pow(i, 43) / 64'd43;
    acc = acc + arc_pow(i, 45) / 64'd45;
    acc = acc - arc_pow(i, 47) / 64'd47;
    acc = acc + arc_pow(i, 49) / 64'd49;
    acc = acc - arc_pow(i, 51) / 64'd51;
    acc = acc + arc_pow(i, 53) / 64'd53;
    acc = acc - arc_pow(i, 55) / 64'd55;
    acc = acc + arc_pow(i, 57) / 64'd57;
    acc = acc - arc_pow(i, 59) / 64'd59;
    return ANG_W'((acc + (64'd1 << 27)) >> 28);
  endfunction

endpackage

@@ hdl/dfs_if.sv @@
// valid/ready channel interfaces for angle input and sine output
interface dfs_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [dfs_pkg::WHOLE_W-1:0]  whole_part;
  logic        [dfs_pkg::HUND_W-1:0]   hundredths;

  modport source (output valid, output whole_part, output hundredths, input ready);
  modport sink   (input valid, input whole_part, input hundredths, output ready);
endinterface

interface dfs_out_if;
  logic                        valid;
  logic                        ready;
  logic [dfs_pkg::BYTE_W-1:0]  low_byte;
  logic [dfs_pkg::BYTE_W-1:0]  high_byte;

  modport source (output valid, output low_byte, output high_byte, input ready);
  modport sink   (input valid, input low_byte, input high_byte, output ready);
endinterface

@@ hdl/dfs_angle.sv @@
// angle front end: hundredths to Q32, reduction modulo two pi and fold into +/- pi/2
module dfs_angle (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               in_valid_i,
  input  logic signed [dfs_pkg::WHOLE_W-1:0] whole_part_i,
  input  logic        [dfs_pkg::HUND_W-1:0]  hundredths_i,
  output dfs_pkg::dfs_ang_t                  ang_o
);

  localparam int unsigned NSTG  = 5 + dfs_pkg::MOD_STEPS;
  localparam int unsigned AIN_W = dfs_pkg::AIN_W;
  localparam int unsigned ANG_W = dfs_pkg::ANG_W;
  localparam int unsigned Q_W   = dfs_pkg::Q_W;
  localparam int unsigned MSTEP = dfs_pkg::MOD_STEPS;

  logic [NSTG-1:0] vld_q, vld_d;

  assign vld_d = {vld_q[NSTG-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= vld_d;
    end
  end

  // stage 1: signed angle in hundredths, its magnitude and the remainder term
  logic signed [AIN_W-1:0]          whole_ext, hund_ext, ain, ain_abs;
  logic [dfs_pkg::MAG_W-1:0]        s1_mag_d, s1_mag_q;
  logic [dfs_pkg::V_W-1:0]          s1_v_d, s1_v_q;
  logic                             s1_neg_q;

  always_comb begin
    whole_ext = AIN_W'(whole_part_i);
    hund_ext  = signed'(AIN_W'(hundredths_i));
    if (whole_part_i > 8'sd0) begin
      ain = whole_ext * dfs_pkg::HUND_PER_UNIT + hund_ext;
    end else begin
      ain = whole_ext * dfs_pkg::HUND_PER_UNIT - hund_ext;
    end
    ain_abs  = ain[AIN_W-1] ? -ain : ain;
    s1_mag_d = ain_abs[dfs_pkg::MAG_W-1:0];
    s1_v_d   = dfs_pkg::V_W'(s1_mag_d) * dfs_pkg::RECIP_REM + dfs_pkg::ROUND_HALF;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_mag_q <= s1_mag_d;
      s1_v_q   <= s1_v_d;
      s1_neg_q <= ain[AIN_W-1];
    end
  end

  // stage 2: mag * floor(2^32/100) and rounded share of the remainder
  logic [Q_W-1:0]                s2_p1_q;
  logic [dfs_pkg::PROD2_W-1:0]   prod2;
  logic [dfs_pkg::QS_W-1:0]      s2_qs_q;
  logic                          s2_neg_q;

  assign prod2 = dfs_pkg::PROD2_W'(s1_v_q) * dfs_pkg::DIV_MUL;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_p1_q  <= Q_W'(s1_mag_q) * dfs_pkg::RECIP_HI;
      s2_qs_q  <= prod2[dfs_pkg::DIV_SHIFT +: dfs_pkg::QS_W];
      s2_neg_q <= s1_neg_q;
    end
  end

  // stage 3: full Q32 magnitude
  logic [Q_W-1:0] s3_q_q;
  logic           s3_neg_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_q_q   <= s2_p1_q + Q_W'(s2_qs_q);
      s3_neg_q <= s2_neg_q;
    end
  end

  // reduction modulo two pi, one conditional subtract of a power-of-two multiple per stage
  logic [Q_W-1:0] mod_in  [MSTEP];
  logic [Q_W-1:0] mod_q   [MSTEP];
  logic           mneg_in [MSTEP];
  logic           mneg_q  [MSTEP];

  assign mod_in[0]  = s3_q_q;
  assign mneg_in[0] = s3_neg_q;

  for (genvar j = 0; j < MSTEP; j++) begin : g_mod
    localparam logic [Q_W-1:0] STEP = Q_W'(dfs_pkg::Q_TWO_PI) << (MSTEP - 1 - j);
    if (j > 0) begin : g_link
      assign mod_in[j]  = mod_q[j-1];
      assign mneg_in[j] = mneg_q[j-1];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        mod_q[j]  <= (mod_in[j] >= STEP) ? mod_in[j] - STEP : mod_in[j];
        mneg_q[j] <= mneg_in[j];
      end
    end
  end

  // wrap into (-pi, pi] and restore the sign
  logic signed [ANG_W-1:0] m_red, m_wrap, s9_m_d, s9_m_q;

  always_comb begin
    m_red  = signed'(ANG_W'(mod_q[MSTEP-1]));
    m_wrap = (m_red > dfs_pkg::Q_PI) ? m_red - dfs_pkg::Q_TWO_PI : m_red;
    s9_m_d = mneg_q[MSTEP-1] ? -m_wrap : m_wrap;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s9_m_q <= s9_m_d;
    end
  end

  // fold into [-pi/2, pi/2]
  logic signed [ANG_W-1:0] s10_r_d, s10_r_q;

  always_comb begin
    priority if (s9_m_q > dfs_pkg::Q_HALF_PI) begin
      s10_r_d = dfs_pkg::Q_PI - s9_m_q;
    end else if (s9_m_q < -dfs_pkg::Q_HALF_PI) begin
      s10_r_d = -dfs_pkg::Q_PI - s9_m_q;
    end else begin
      s10_r_d = s9_m_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s10_r_q <= s10_r_d;
    end
  end

  assign ang_o.valid = vld_q[NSTG-1];
  assign ang_o.angle = s10_r_q;

endmodule

@@ hdl/dfs_cordic.sv @@
// rotation-mode cordic, one micro-rotation per pipeline stage
module dfs_cordic #(
  parameter int unsigned STAGES = dfs_pkg::CORDIC_STAGES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  dfs_pkg::dfs_ang_t ang_i,
  output dfs_pkg::dfs_rot_t rot_o
);

  localparam int unsigned ANG_W = dfs_pkg::ANG_W;

  logic [STAGES-1:0] vld_q, vld_d;

  assign vld_d = {vld_q[STAGES-2:0], ang_i.valid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= vld_d;
    end
  end

  logic signed [ANG_W-1:0] x_in [STAGES];
  logic signed [ANG_W-1:0] y_in [STAGES];
  logic signed [ANG_W-1:0] z_in [STAGES];
  logic signed [ANG_W-1:0] x_q  [STAGES];
  logic signed [ANG_W-1:0] y_q  [STAGES];
  logic signed [ANG_W-1:0] z_q  [STAGES];

  assign x_in[0] = dfs_pkg::Q_GAIN;
  assign y_in[0] = '0;
  assign z_in[0] = ang_i.angle;

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam logic signed [ANG_W-1:0] ATAN = dfs_pkg::arc_step(i);

    logic signed [ANG_W-1:0] dx, dy;

    if (i > 0) begin : g_link
      assign x_in[i] = x_q[i-1];
      assign y_in[i] = y_q[i-1];
      assign z_in[i] = z_q[i-1];
    end

    // arithmetic shifts round toward minus infinity
    assign dx = y_in[i] >>> i;
    assign dy = x_in[i] >>> i;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_in[i][ANG_W-1]) begin
          x_q[i] <= x_in[i] - dx;
          y_q[i] <= y_in[i] + dy;
          z_q[i] <= z_in[i] - ATAN;
        end else begin
          x_q[i] <= x_in[i] + dx;
          y_q[i] <= y_in[i] - dy;
          z_q[i] <= z_in[i] + ATAN;
        end
      end
    end
  end

  assign rot_o.valid = vld_q[STAGES-1];
  assign rot_o.y     = y_q[STAGES-1];

endmodule

@@ hdl/dfs_scale.sv @@
// sine times 100, truncation, saturation and two-entry output buffer
module dfs_scale (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  dfs_pkg::dfs_rot_t          rot_i,
  output logic                       en_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [dfs_pkg::BYTE_W-1:0] low_byte_o,
  output logic [dfs_pkg::BYTE_W-1:0] high_byte_o
);

  localparam int unsigned ANG_W = dfs_pkg::ANG_W;
  localparam int unsigned RES_W = dfs_pkg::RES_W;

  logic                       en;
  logic [ANG_W-1:0]           y_abs;
  logic [dfs_pkg::PROD_W-1:0] prod;

  assign y_abs = rot_i.y[ANG_W-1] ? unsigned'(-rot_i.y) : unsigned'(rot_i.y);
  assign prod  = dfs_pkg::PROD_W'(y_abs) * dfs_pkg::SCALE;

  // stage a: floor(|y| * 100 / 2^32)
  logic                      a_vld_q;
  logic [dfs_pkg::SCL_W-1:0] a_mag_q;
  logic                      a_neg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (en) begin
      a_vld_q <= rot_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_mag_q <= prod[32 +: dfs_pkg::SCL_W];
      a_neg_q <= rot_i.y[ANG_W-1];
    end
  end

  // saturate and apply sign; zero stays zero
  logic [dfs_pkg::SAT_W-1:0] sat;
  logic [RES_W-1:0]          res;

  always_comb begin
    sat = (a_mag_q > dfs_pkg::SAT_MAX) ? dfs_pkg::SAT_MAX[dfs_pkg::SAT_W-1:0]
                                       : a_mag_q[dfs_pkg::SAT_W-1:0];
    res = a_neg_q ? -RES_W'(sat) : RES_W'(sat);
  end

  // output register plus skid entry; the pipeline stops only when both are full
  logic             out_vld_q, skid_vld_q;
  logic [RES_W-1:0] out_res_q, skid_res_q;
  logic             push, pop;

  assign en   = !skid_vld_q;
  assign push = en && a_vld_q;
  assign pop  = out_vld_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (!out_vld_q || pop) begin
        if (skid_vld_q) begin
          out_vld_q  <= 1'b1;
          skid_vld_q <= 1'b0;
        end else begin
          out_vld_q  <= push;
        end
      end else if (push) begin
        skid_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || pop) begin
      out_res_q <= skid_vld_q ? skid_res_q : res;
    end
    if (out_vld_q && !pop && push) begin
      skid_res_q <= res;
    end
  end

  assign en_o        = en;
  assign out_valid_o = out_vld_q;
  assign low_byte_o  = out_res_q[dfs_pkg::BYTE_W-1:0];
  assign high_byte_o = out_res_q[RES_W-1:dfs_pkg::BYTE_W];

endmodule

@@ hdl/decimal_fixed_sine_top.sv @@
// throughput: one angle per cycle while the output buffer has a free entry; the angle front end
// takes 10 stages, the cordic one stage per micro-rotation, scaling one stage and the output
// register one more; a two-entry output buffer lets the pipeline keep moving while one result waits
// reset: asynchronous, active low; clears all valid bits and the output buffer
module decimal_fixed_sine_top #(
  parameter int unsigned CORDIC_STAGES = dfs_pkg::CORDIC_STAGES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dfs_in_if.sink     in_if_i,
  dfs_out_if.source  out_if_o
);

  logic              en;
  dfs_pkg::dfs_ang_t ang;
  dfs_pkg::dfs_rot_t rot;

  assign in_if_i.ready = en;

  dfs_angle u_angle (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .in_valid_i   (in_if_i.valid),
    .whole_part_i (in_if_i.whole_part),
    .hundredths_i (in_if_i.hundredths),
    .ang_o        (ang)
  );

  dfs_cordic #(
    .STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .ang_i  (ang),
    .rot_o  (rot)
  );

  dfs_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rot_i       (rot),
    .en_o        (en),
    .out_valid_o (out_if_o.valid),
    .out_ready_i (out_if_o.ready),
    .low_byte_o  (out_if_o.low_byte),
    .high_byte_o (out_if_o.high_byte)
  );

endmodule

@@ hdl/dfs_checker.sv @@
// port-level checks for the decimal sine block, bound to the top level
module dfs_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [dfs_pkg::BYTE_W-1:0] low_byte_i,
  input logic [dfs_pkg::BYTE_W-1:0] high_byte_i
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(low_byte_i) && $stable(high_byte_i))
    else $error("result changed while stalled");

  // results lie in -100..100 with a clean sign byte
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (high_byte_i == 8'h00 && low_byte_i <= 8'd100) ||
                    (high_byte_i == 8'hFF && low_byte_i >= 8'h9C))
    else $error("result outside -100..100");

  // input back-pressure only while a result is waiting
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled with no result waiting");

endmodule

bind decimal_fixed_sine_top dfs_checker u_dfs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_if_i.ready),
  .out_valid_i (out_if_o.valid),
  .out_ready_i (out_if_o.ready),
  .low_byte_i  (out_if_o.low_byte),
  .high_byte_i (out_if_o.high_byte)
);
